// ===== rtl/core/rims_pkg.sv =====
// Shared constants, datapath opcodes, controller states and status struct for the run sorter.
`timescale 1ns / 1ps

package rims_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int RUN_LENGTH = 32;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = $clog2(MAX_ITEMS);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  // positions, run bounds and merge widths; one extra bit covers lo + 2*width
  localparam int POS_W      = CNT_W + 1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_STORE,
    OP_RUN_SETUP,
    OP_RUN_NEXT,
    OP_INS_READ,
    OP_INS_LOAD,
    OP_INS_SHIFT,
    OP_INS_PUT,
    OP_MRG_INIT,
    OP_PASS_NEXT,
    OP_COPY_INIT,
    OP_COPY,
    OP_PAIR_INIT,
    OP_PAIR_SETUP,
    OP_MERGE,
    OP_OUT_INIT,
    OP_OUT_LOAD,
    OP_DONE
  } op_t;

  typedef enum logic [3:0] {
    S_COLLECT,
    S_RUN_SETUP,
    S_INS_CHECK,
    S_INS_LOAD,
    S_INS_CMP,
    S_INS_PUT,
    S_MRG_SETUP,
    S_PASS_CHECK,
    S_COPY,
    S_PAIR_INIT,
    S_PAIR_SETUP,
    S_MERGE,
    S_OUT_LOAD,
    S_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic i_gt_hi;     // insertion index ran past the run end
    logic run_last;    // current run is the final one
    logic shift;       // element left of the hole is larger than the held value
    logic j_low;       // hole reaches the run start after this shift
    logic pass_done;   // merge width covers the whole set
    logic copy_last;   // copy to scratch reaches the final element
    logic pair_done;   // no right neighbour left in this pass
    logic merge_last;  // merge writes the final element of the pair
    logic out_last;    // result in the output register is the final one
  } stat_t;

endpackage

// ===== rtl/core/rims_ctrl.sv =====
// Controller state machine: sequences collection, insertion, merge passes and output.
`timescale 1ns / 1ps

module rims_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tlast,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  rims_pkg::stat_t stat,
  output rims_pkg::op_t  op
);
  import rims_pkg::*;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_COLLECT:    if (in_fire && in_tlast) state_nxt = S_RUN_SETUP;
      S_RUN_SETUP:  state_nxt = S_INS_CHECK;
      S_INS_CHECK: begin
        if (!stat.i_gt_hi)      state_nxt = S_INS_LOAD;
        else if (stat.run_last) state_nxt = S_MRG_SETUP;
        else                    state_nxt = S_RUN_SETUP;
      end
      S_INS_LOAD:   state_nxt = S_INS_CMP;
      S_INS_CMP: begin
        if (!stat.shift)    state_nxt = S_INS_CHECK;
        else if (stat.j_low) state_nxt = S_INS_PUT;
      end
      S_INS_PUT:    state_nxt = S_INS_CHECK;
      S_MRG_SETUP:  state_nxt = S_PASS_CHECK;
      S_PASS_CHECK: state_nxt = stat.pass_done ? S_OUT_LOAD : S_COPY;
      S_COPY:       if (stat.copy_last) state_nxt = S_PAIR_INIT;
      S_PAIR_INIT:  state_nxt = S_PAIR_SETUP;
      S_PAIR_SETUP: state_nxt = stat.pair_done ? S_PASS_CHECK : S_MERGE;
      S_MERGE:      if (stat.merge_last) state_nxt = S_PAIR_SETUP;
      S_OUT_LOAD:   state_nxt = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (out_tready) state_nxt = stat.out_last ? S_COLLECT : S_OUT_LOAD;
      end
      default:      state_nxt = S_COLLECT;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    op         = OP_NONE;
    unique case (state_r)
      S_COLLECT: begin
        in_tready = 1'b1;
        if (in_fire) op = OP_STORE;
      end
      S_RUN_SETUP:  op = OP_RUN_SETUP;
      S_INS_CHECK:  op = stat.i_gt_hi ? OP_RUN_NEXT : OP_INS_READ;
      S_INS_LOAD:   op = OP_INS_LOAD;
      S_INS_CMP:    op = stat.shift ? OP_INS_SHIFT : OP_INS_PUT;
      S_INS_PUT:    op = OP_INS_PUT;
      S_MRG_SETUP:  op = OP_MRG_INIT;
      S_PASS_CHECK: op = stat.pass_done ? OP_OUT_INIT : OP_COPY_INIT;
      S_COPY:       op = OP_COPY;
      S_PAIR_INIT:  op = OP_PAIR_INIT;
      S_PAIR_SETUP: op = stat.pair_done ? OP_PASS_NEXT : OP_PAIR_SETUP;
      S_MERGE:      op = OP_MERGE;
      S_OUT_LOAD:   op = OP_OUT_LOAD;
      S_OUT_WAIT: begin
        out_tvalid = 1'b1;
        if (out_tready && stat.out_last) op = OP_DONE;
      end
      default:      op = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/rims_datapath.sv =====
// Datapath: value and scratch memories, position counters, comparator and output register.
`timescale 1ns / 1ps

module rims_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rims_pkg::op_t                op,
  input  logic [rims_pkg::DATA_W-1:0]  in_value,
  output rims_pkg::stat_t              stat,
  output logic [rims_pkg::DATA_W-1:0]  out_value,
  output logic                         out_last,
  output logic                         out_over
);
  import rims_pkg::*;

  localparam logic [POS_W-1:0] RL_POS  = POS_W'(RUN_LENGTH);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);
  localparam logic [POS_W-1:0] ONE     = POS_W'(1);
  localparam logic [POS_W-1:0] TWO     = POS_W'(2);

  logic [DATA_W-1:0] data_mem [MAX_ITEMS];
  logic [DATA_W-1:0] scr_mem  [MAX_ITEMS];

  logic [CNT_W-1:0]  cnt_r;
  logic              drop_r;
  logic [POS_W-1:0]  lo_r, hi_r, mid_r, i_r, j_r, t_r, k_r, a_r, b_r, width_r;
  logic [DATA_W-1:0] cur_r, rd_r, sa_r, sb_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r, out_over_r;

  logic [POS_W-1:0]  n_pos, n_m1, run_end, pair_end, a_nxt, b_nxt;
  logic [POS_W-1:0]  data_raddr, sa_raddr, sb_raddr, data_waddr;
  logic [DATA_W-1:0] data_wdata;
  logic              data_we, scr_we, cnt_full, take_left;

  assign n_pos    = POS_W'(cnt_r);
  assign n_m1     = n_pos - ONE;
  assign cnt_full = (cnt_r == MAX_CNT);
  assign run_end  = (lo_r + RL_POS - ONE > n_m1) ? n_m1 : lo_r + RL_POS - ONE;
  assign pair_end = (lo_r + (width_r << 1) - ONE > n_m1) ? n_m1
                                                         : lo_r + (width_r << 1) - ONE;

  // stable merge: left run wins ties, and takes over once the right run is empty
  assign take_left = (a_r <= mid_r) &&
                     ((b_r > hi_r) || !($signed(sa_r) > $signed(sb_r)));
  assign a_nxt     = take_left ? a_r + ONE : a_r;
  assign b_nxt     = take_left ? b_r : b_r + ONE;

  always_comb begin
    stat.i_gt_hi    = (i_r > hi_r);
    stat.run_last   = (lo_r + RL_POS >= n_pos);
    stat.shift      = ($signed(rd_r) > $signed(cur_r));
    stat.j_low      = (j_r - ONE == lo_r);
    stat.pass_done  = (width_r >= n_pos);
    stat.copy_last  = (t_r == n_m1);
    stat.pair_done  = (lo_r + width_r >= n_pos);
    stat.merge_last = (k_r == hi_r);
    stat.out_last   = out_last_r;
  end

  // memory port selection
  always_comb begin
    data_raddr = t_r;
    sa_raddr   = a_r;
    sb_raddr   = b_r;
    data_we    = 1'b0;
    data_waddr = j_r;
    data_wdata = cur_r;
    scr_we     = 1'b0;
    unique case (op)
      OP_STORE: begin
        data_we    = !cnt_full;
        data_waddr = n_pos;
        data_wdata = in_value;
      end
      OP_INS_READ:  data_raddr = i_r;
      OP_INS_LOAD:  data_raddr = i_r - ONE;
      OP_INS_SHIFT: begin
        data_raddr = j_r - TWO;
        data_we    = 1'b1;
        data_wdata = rd_r;
      end
      OP_INS_PUT:   data_we = 1'b1;
      OP_COPY_INIT: data_raddr = '0;
      OP_COPY: begin
        data_raddr = t_r + ONE;
        scr_we     = 1'b1;
      end
      OP_PAIR_SETUP: begin
        sa_raddr = lo_r;
        sb_raddr = lo_r + width_r;
      end
      OP_MERGE: begin
        sa_raddr   = a_nxt;
        sb_raddr   = b_nxt;
        data_we    = 1'b1;
        data_waddr = k_r;
        data_wdata = take_left ? sa_r : sb_r;
      end
      OP_OUT_INIT:  data_raddr = '0;
      default:      data_raddr = t_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_waddr[IDX_W-1:0]] <= data_wdata;
    rd_r <= data_mem[data_raddr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[t_r[IDX_W-1:0]] <= rd_r;
    sa_r <= scr_mem[sa_raddr[IDX_W-1:0]];
    sb_r <= scr_mem[sb_raddr[IDX_W-1:0]];
  end

  // set occupancy and drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else if (op == OP_STORE) begin
      if (cnt_full) drop_r <= 1'b1;
      else          cnt_r  <= cnt_r + CNT_W'(1);
    end else if (op == OP_DONE) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_STORE:     lo_r <= '0;
      OP_RUN_SETUP: begin
        hi_r <= run_end;
        i_r  <= lo_r + ONE;
      end
      OP_RUN_NEXT:  lo_r <= lo_r + RL_POS;
      OP_INS_LOAD: begin
        cur_r <= rd_r;
        j_r   <= i_r;
      end
      OP_INS_SHIFT: j_r <= j_r - ONE;
      OP_INS_PUT:   i_r <= i_r + ONE;
      OP_MRG_INIT:  width_r <= RL_POS;
      OP_PASS_NEXT: width_r <= width_r << 1;
      OP_COPY_INIT: t_r <= '0;
      OP_COPY:      t_r <= t_r + ONE;
      OP_PAIR_INIT: lo_r <= '0;
      OP_PAIR_SETUP: begin
        mid_r <= lo_r + width_r - ONE;
        hi_r  <= pair_end;
        a_r   <= lo_r;
        b_r   <= lo_r + width_r;
        k_r   <= lo_r;
      end
      OP_MERGE: begin
        a_r <= a_nxt;
        b_r <= b_nxt;
        k_r <= k_r + ONE;
        if (k_r == hi_r) lo_r <= lo_r + (width_r << 1);
      end
      OP_OUT_INIT:  t_r <= '0;
      OP_OUT_LOAD: begin
        out_value_r <= rd_r;
        out_last_r  <= (t_r == n_m1);
        out_over_r  <= drop_r;
        t_r         <= t_r + ONE;
      end
      default: ;
    endcase
  end

  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_over  = out_over_r;

endmodule

// ===== rtl/core/run_insertion_merge_sort_unit.sv =====
// Operation: n accepted transactions fill the set, then each run is insertion-sorted
// (one shift per cycle on the value memory port), merge passes follow, and each result is
// loaded and then held until taken; throughput is one set at a time, no input during sort/output.
// Reset: synchronous active-low; clears controller state, item count and drop flag.
// The value and scratch memories are not cleared and are read only where written.
`timescale 1ns / 1ps

module run_insertion_merge_sort_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rims_pkg::DATA_W-1:0] in_tdata,   // [31:0] value
  input  logic                        in_tlast,   // last
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rims_pkg::DATA_W-1:0] out_tdata,  // [31:0] sorted_value
  output logic                        out_tlast,  // final_res
  output logic                        out_tuser   // [0] overflow
);
  import rims_pkg::*;

  op_t   op;
  stat_t stat;

  rims_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .op         (op)
  );

  rims_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_value  (in_tdata),
    .stat      (stat),
    .out_value (out_tdata),
    .out_last  (out_tlast),
    .out_over  (out_tuser)
  );

endmodule
